// File: hdl/mbv_pkg.sv
// ----------------------------------------------------------------------------
// mbv_pkg
// Shared types and constants of the masked bit majority vote.
// ----------------------------------------------------------------------------
package mbv_pkg;

    localparam int IN_BITS   = 16;  // templates carried per input item
    localparam int CNT_W     = 5;   // holds a count of 0..16
    localparam int FRAC_W    = 17;  // Q0.16 with room for 1.0
    localparam int Q16_SHIFT = 16;
    localparam int RECIP_W   = 33;  // ceil(2^32 / d), d = 1 holds 2^32
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_FRACTION_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSISTENCY_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_INCONSISTENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_WEIGHT   = 3'd4;

    // ceil(2^32 / d) for d = 1..16; floor(a * 2^16 / d) = (a * RECIP[d]) >> 16
    // is exact for a <= d <= 16. Entry 0 is never used.
    localparam logic [RECIP_W-1:0] RECIP_TBL [0:IN_BITS] = '{
        33'd0,
        33'd4294967296, 33'd2147483648, 33'd1431655766, 33'd1073741824,
        33'd858993460,  33'd715827883,  33'd613566757,  33'd536870912,
        33'd477218589,  33'd429496730,  33'd390451573,  33'd357913942,
        33'd330382100,  33'd306783379,  33'd286331154,  33'd268435456
    };

    typedef struct packed {
        logic [CNT_W-1:0]  n;          // voting templates after clamping
        logic [FRAC_W-1:0] mask_min;
        logic [FRAC_W-1:0] cons_min;
        logic              keep;
        logic [FRAC_W-1:0] fallback;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] valid_cnt;   // valid templates
        logic [CNT_W-1:0] agree;       // valid templates agreeing with the vote
        logic             voted;       // strict majority of the valid code bits
    } t_vote;

endpackage

// File: hdl/mbv_front.sv
// ----------------------------------------------------------------------------
// mbv_front
// Counts valid and agreeing templates of one bit position and forms the vote.
// ----------------------------------------------------------------------------
module mbv_front
    import mbv_pkg::*;
(
    input  logic [CNT_W-1:0]   i_n,
    input  logic [IN_BITS-1:0] i_code_bits,
    input  logic [IN_BITS-1:0] i_valid_bits,
    output t_vote              o_vote
);

    logic [IN_BITS-1:0] sel;
    logic [IN_BITS-1:0] vb;
    logic [IN_BITS-1:0] cb;
    logic [2:0]         nib_v [4];
    logic [2:0]         nib_c [4];
    logic [CNT_W-1:0]   valid_cnt;
    logic [CNT_W-1:0]   ones_cnt;
    logic               voted;

    always_comb begin
        for (int i = 0; i < IN_BITS; i++) begin
            sel[i] = (CNT_W'(i) < i_n);
        end
    end

    assign vb = i_valid_bits & sel;
    assign cb = i_code_bits & vb;

    // two-level count: four nibbles, then their sum
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nib_v[k] = 3'(vb[4*k]) + 3'(vb[4*k+1]) + 3'(vb[4*k+2]) + 3'(vb[4*k+3]);
            nib_c[k] = 3'(cb[4*k]) + 3'(cb[4*k+1]) + 3'(cb[4*k+2]) + 3'(cb[4*k+3]);
        end
    end

    assign valid_cnt = (CNT_W'(nib_v[0]) + CNT_W'(nib_v[1]))
                     + (CNT_W'(nib_v[2]) + CNT_W'(nib_v[3]));
    assign ones_cnt  = (CNT_W'(nib_c[0]) + CNT_W'(nib_c[1]))
                     + (CNT_W'(nib_c[2]) + CNT_W'(nib_c[3]));

    assign voted = ({ones_cnt, 1'b0} > {1'b0, valid_cnt});

    assign o_vote.valid_cnt = valid_cnt;
    assign o_vote.agree     = voted ? ones_cnt : (valid_cnt - ones_cnt);
    assign o_vote.voted     = voted;

endmodule

// File: hdl/mbv_fifo.sv
// ----------------------------------------------------------------------------
// mbv_fifo
// Short show-ahead queue of counted positions between front and back.
// ----------------------------------------------------------------------------
module mbv_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// File: hdl/mbv_back.sv
// ----------------------------------------------------------------------------
// mbv_back
// Threshold tests and weight of one position, two stages with stall.
// ----------------------------------------------------------------------------
module mbv_back
    import mbv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_entry_vld,
    input  t_vote             i_entry,
    output logic              o_pop,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic              o_bit,
    output logic              o_keep,
    output logic [FRAC_W-1:0] o_weight
);

    localparam int THR_W  = FRAC_W + CNT_W;        // threshold products
    localparam int PROD_W = CNT_W + RECIP_W;       // weight product

    // stage A: products
    logic              r_a_vld;
    logic              r_a_zero;
    logic              r_a_bit;
    logic [CNT_W-1:0]  r_a_valid_cnt;
    logic [CNT_W-1:0]  r_a_agree;
    logic [THR_W-1:0]  r_a_frac_prod;
    logic [THR_W-1:0]  r_a_cons_prod;
    logic [PROD_W-1:0] r_a_w_prod;

    // stage B: result register
    logic              r_b_vld;
    logic              r_b_bit;
    logic              r_b_keep;
    logic [FRAC_W-1:0] r_b_weight;

    logic              adv_a;
    logic              adv_b;
    logic              reject;
    logic              confident;
    logic              n_b_bit;
    logic              n_b_keep;
    logic [FRAC_W-1:0] n_b_weight;
    logic [THR_W-1:0]  valid_scaled;
    logic [THR_W-1:0]  agree_scaled;

    assign adv_b = !r_b_vld || i_rdy;
    assign adv_a = !r_a_vld || adv_b;
    assign o_pop = i_entry_vld && adv_a;

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_zero      <= (i_entry.valid_cnt == '0);
            r_a_bit       <= i_entry.voted;
            r_a_valid_cnt <= i_entry.valid_cnt;
            r_a_agree     <= i_entry.agree;
            r_a_frac_prod <= THR_W'(i_cfg.n) * THR_W'(i_cfg.mask_min);
            r_a_cons_prod <= THR_W'(i_entry.valid_cnt) * THR_W'(i_cfg.cons_min);
            r_a_w_prod    <= PROD_W'(i_entry.agree)
                           * PROD_W'(RECIP_TBL[i_entry.valid_cnt]);
        end
    end

    assign valid_scaled = THR_W'({r_a_valid_cnt, {Q16_SHIFT{1'b0}}});
    assign agree_scaled = THR_W'({r_a_agree, {Q16_SHIFT{1'b0}}});
    assign reject       = r_a_zero || (valid_scaled < r_a_frac_prod);
    assign confident    = (agree_scaled >= r_a_cons_prod);

    always_comb begin
        n_b_bit    = 1'b0;
        n_b_keep   = 1'b0;
        n_b_weight = '0;
        if (!reject) begin
            n_b_bit = r_a_bit;
            if (confident) begin
                n_b_keep   = 1'b1;
                n_b_weight = r_a_w_prod[Q16_SHIFT +: FRAC_W];
            end else if (i_cfg.keep) begin
                n_b_keep   = 1'b1;
                n_b_weight = i_cfg.fallback;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_bit    <= n_b_bit;
            r_b_keep   <= n_b_keep;
            r_b_weight <= n_b_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_entry_vld;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    assign o_vld    = r_b_vld;
    assign o_bit    = r_b_bit;
    assign o_keep   = r_b_keep;
    assign o_weight = r_b_weight;

    a_pop_fills_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_a_vld)
        else $error("popped entry lost before stage A");

    a_masked_no_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !r_b_keep) |-> (r_b_weight == '0))
        else $error("weight on a masked position");

endmodule

// File: hdl/masked_bit_majority_vote.sv
// ----------------------------------------------------------------------------
// masked_bit_majority_vote
// Masked bitwise majority vote over aligned templates, one bit position per
// transfer, with a Q0.16 consistency weight for each voted bit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | i_s_axis_tvalid/o_..._tready | code_bits, valid_bits
//  m_axis   | out       | o_m_axis_tvalid/i_..._tready | voted_bit, voted_valid,
//           |           |                              | bit_weight
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | register index, data
//
// One position per cycle sustained while the output is ready; three register
// stages (queue, products, threshold tests) lie between an input transfer and
// its result transfer.
// The queue holds FIFO_DEPTH positions, so the input keeps moving while the
// output stalls until the queue fills; o_s_axis_tready drops only when full,
// including the cycle in which a full queue pops.
// Synchronous active-low reset empties the pipeline and loads register
// defaults (template_count 1, all others 0). The cfg port is always ready.
// ----------------------------------------------------------------------------
module masked_bit_majority_vote
    import mbv_pkg::*;
#(
    parameter int MAX_TEMPLATES = 16,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,   // [15:0] code_bits, [31:16] valid_bits
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,   // [0] voted_bit, [1] voted_valid,
                                                   // [18:2] bit_weight, zero above
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data
);

    localparam int NCAP = (MAX_TEMPLATES < IN_BITS) ? MAX_TEMPLATES : IN_BITS;
    localparam int QW   = $bits(t_vote);

    logic [CNT_W-1:0]  r_template_count;
    logic [FRAC_W-1:0] r_mask_min;
    logic [FRAC_W-1:0] r_cons_min;
    logic              r_keep;
    logic [FRAC_W-1:0] r_fallback;

    t_cfg              cfg;
    t_vote             front_vote;
    t_vote             back_entry;
    logic [QW-1:0]     q_dout;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    logic              b_bit;
    logic              b_keep;
    logic [FRAC_W-1:0] b_weight;

    // ---- configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_template_count <= CNT_W'(1);
            r_mask_min       <= '0;
            r_cons_min       <= '0;
            r_keep           <= 1'b0;
            r_fallback       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMPLATE_COUNT:    r_template_count <= i_cfg_data[CNT_W-1:0];
                CFG_MASK_FRACTION_MIN: r_mask_min       <= i_cfg_data;
                CFG_CONSISTENCY_MIN:   r_cons_min       <= i_cfg_data;
                CFG_KEEP_INCONSISTENT: r_keep           <= i_cfg_data[0];
                CFG_FALLBACK_WEIGHT:   r_fallback       <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg.n        = (r_template_count > CNT_W'(NCAP)) ? CNT_W'(NCAP)
                                                            : r_template_count;
    assign cfg.mask_min = r_mask_min;
    assign cfg.cons_min = r_cons_min;
    assign cfg.keep     = r_keep;
    assign cfg.fallback = r_fallback;

    // ---- front: count and vote
    mbv_front u_front (
        .i_n          (cfg.n),
        .i_code_bits  (i_s_axis_tdata[15:0]),
        .i_valid_bits (i_s_axis_tdata[31:16]),
        .o_vote       (front_vote)
    );

    assign o_s_axis_tready = !q_full;
    assign q_push          = i_s_axis_tvalid && !q_full;

    mbv_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_vote),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_dout)
    );

    assign back_entry = t_vote'(q_dout);

    // ---- back: thresholds and weight
    mbv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_entry_vld (!q_empty),
        .i_entry     (back_entry),
        .o_pop       (q_pop),
        .o_vld       (o_m_axis_tvalid),
        .i_rdy       (i_m_axis_tready),
        .o_bit       (b_bit),
        .o_keep      (b_keep),
        .o_weight    (b_weight)
    );

    assign o_m_axis_tdata = {5'b0, b_weight, b_keep, b_bit};

endmodule

// File: tb/mbv_vote_checker.sv
// ----------------------------------------------------------------------------
// mbv_vote_checker
// Watches the position, result and register channels of the majority vote,
// predicts each result from its own copy of the registers and compares every
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbv_vote_checker
    import mbv_pkg::*;
#(
    parameter int MAX_TEMPLATES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [31:0]          i_in_data,    // [15:0] code_bits, [31:16] valid_bits
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [23:0]          i_out_data,   // [0] voted_bit, [1] voted_valid,
                                               // [18:2] bit_weight, zero above
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAC_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam longint unsigned Q16_ONE = 64'd1 << Q16_SHIFT;

    // packed from the top down, so voted_bit lands in bit 0
    typedef struct packed {
        logic [FRAC_W-1:0] bit_weight;
        logic              voted_valid;
        logic              voted_bit;
    } t_vote_result;

    logic [CNT_W-1:0]  tpl_count;
    logic [FRAC_W-1:0] mask_min;
    logic [FRAC_W-1:0] cons_min;
    logic              keep_weak;
    logic [FRAC_W-1:0] fallback;

    t_vote_result expected_votes[$];
    int           fail_total;

    function automatic t_vote_result predict_vote(input logic [IN_BITS-1:0] code,
                                                  input logic [IN_BITS-1:0] valid);
        longint unsigned n, valid_cnt, ones, agree;
        logic [IN_BITS-1:0] sel, vb, cb;
        t_vote_result r;
        r = '0;
        n = tpl_count;
        if (n > MAX_TEMPLATES) n = MAX_TEMPLATES;
        if (n > IN_BITS) n = IN_BITS;
        sel = '0;
        for (int i = 0; i < IN_BITS; i++) begin
            if (i < n) sel[i] = 1'b1;
        end
        vb = valid & sel;
        cb = code & vb;
        valid_cnt = $countones(vb);
        ones = $countones(cb);
        // reject: nothing valid, or too small a valid fraction
        if (valid_cnt == 0) return r;
        if (valid_cnt * Q16_ONE < longint'(mask_min) * n) return r;
        r.voted_bit = (2 * ones > valid_cnt);
        agree = r.voted_bit ? ones : valid_cnt - ones;
        if (agree * Q16_ONE >= longint'(cons_min) * valid_cnt) begin
            r.voted_valid = 1'b1;
            r.bit_weight  = FRAC_W'((agree * Q16_ONE) / valid_cnt);
        end else if (keep_weak) begin
            r.voted_valid = 1'b1;
            r.bit_weight  = fallback;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_vote_result exp_vote, got_vote;
        if (!i_rst_n) begin
            tpl_count = CNT_W'(1);
            mask_min  = '0;
            cons_min  = '0;
            keep_weak = 1'b0;
            fallback  = '0;
            expected_votes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_vote = i_out_data[$bits(t_vote_result)-1:0];
                if (expected_votes.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_out_data);
                    fail_total++;
                end else begin
                    exp_vote = expected_votes.pop_front();
                    if (got_vote.voted_bit !== exp_vote.voted_bit) begin
                        $error("voted_bit: expected %0d, actual %0d",
                               exp_vote.voted_bit, got_vote.voted_bit);
                        fail_total++;
                    end
                    if (got_vote.voted_valid !== exp_vote.voted_valid) begin
                        $error("voted_valid: expected %0d, actual %0d",
                               exp_vote.voted_valid, got_vote.voted_valid);
                        fail_total++;
                    end
                    if (got_vote.bit_weight !== exp_vote.bit_weight) begin
                        $error("bit_weight: expected %0d, actual %0d",
                               exp_vote.bit_weight, got_vote.bit_weight);
                        fail_total++;
                    end
                    if (i_out_data[23:$bits(t_vote_result)] !== '0) begin
                        $error("padding: expected 0, actual %0h",
                               i_out_data[23:$bits(t_vote_result)]);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_votes.insert(expected_votes.size(),
                                      predict_vote(i_in_data[15:0], i_in_data[31:16]));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMPLATE_COUNT:    tpl_count = i_cfg_data[CNT_W-1:0];
                    CFG_MASK_FRACTION_MIN: mask_min  = i_cfg_data;
                    CFG_CONSISTENCY_MIN:   cons_min  = i_cfg_data;
                    CFG_KEEP_INCONSISTENT: keep_weak = i_cfg_data[0];
                    CFG_FALLBACK_WEIGHT:   fallback  = i_cfg_data;
                    default: ;  // drop writes to unused indexes
                endcase
            end
        end
        o_pending    <= expected_votes.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the majority vote with directed corner positions and then random
// phases under random register settings, with bursty input, a stalling
// output and one long output hold; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mbv_pkg::*;

    localparam int NUM_PHASES       = 10;
    localparam int ITEMS_PER_PHASE  = 125;
    localparam int LONG_HOLD        = 64;
    localparam int PRESSURE_ITEMS   = 30;
    localparam int SETTLE_CYCLES    = 6;
    localparam int Q16_ONE          = 65536;
    localparam int FRAC_MAX         = (1 << FRAC_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [31:0]          i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FRAC_W-1:0]    i_cfg_data = '0;

    int pending;
    int fail_count;
    int hold_off_req = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    masked_bit_majority_vote dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    mbv_vote_checker vote_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // hold tvalid high across back-to-back positions; lower it only in gaps
    task automatic send_position(input logic [15:0] code, input logic [15:0] valid);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {valid, code};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        idle_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FRAC_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // narrow registers get junk above their width, which must be dropped
    task automatic load_settings(input int count, input int mask_frac, input int cons_frac,
                                 input bit keep, input int fb);
        drain_results();
        write_register(CFG_TEMPLATE_COUNT,
                       (FRAC_W'($urandom) & ~FRAC_W'(31)) | FRAC_W'(count & 31));
        write_register(CFG_MASK_FRACTION_MIN, FRAC_W'(mask_frac));
        write_register(CFG_CONSISTENCY_MIN, FRAC_W'(cons_frac));
        write_register(CFG_KEEP_INCONSISTENT,
                       (FRAC_W'($urandom) & ~FRAC_W'(1)) | FRAC_W'(keep));
        write_register(CFG_FALLBACK_WEIGHT, FRAC_W'(fb));
    endtask

    task automatic make_position(output logic [15:0] code, output logic [15:0] valid);
        logic [15:0] base, flips;
        base  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        flips = 16'($urandom) & 16'($urandom) & 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                code  = 16'($urandom);
                valid = 16'($urandom);
            end
            1: begin
                valid = 16'hFFFF;
                code  = base ^ flips;
            end
            2: begin
                valid = ~(16'($urandom) & 16'($urandom));
                code  = base ^ flips;
            end
            default: begin
                valid = 16'($urandom) & 16'($urandom);
                code  = 16'($urandom);
            end
        endcase
    endtask

    function automatic int pick_fraction();
        case ($urandom_range(0, 7))
            0, 1:    return 0;
            2:       return Q16_ONE;
            3:       return $urandom_range(Q16_ONE + 1, FRAC_MAX);
            4:       return $urandom_range(Q16_ONE / 2, Q16_ONE);
            default: return $urandom_range(0, Q16_ONE);
        endcase
    endfunction

    task automatic run_random_phase(input int phase);
        int count, mask_frac, fb, burst, back_to_back;
        bit with_gaps, do_pause;
        logic [15:0] code, valid;
        case ($urandom_range(0, 5))
            0:       count = 0;
            1:       count = 1;
            2:       count = 16;
            3:       count = $urandom_range(17, 31);
            default: count = $urandom_range(2, 15);
        endcase
        mask_frac = pick_fraction();
        if (mask_frac > Q16_ONE && $urandom_range(0, 3) != 0) mask_frac = 0;
        case ($urandom_range(0, 3))
            0:       fb = 0;
            1:       fb = Q16_ONE;
            2:       fb = FRAC_MAX;
            default: fb = $urandom_range(0, FRAC_MAX);
        endcase
        load_settings(count, mask_frac, pick_fraction(), 1'($urandom_range(0, 1)), fb);
        with_gaps    = (phase % 3 != 2);
        do_pause     = (phase == 1) || ($urandom_range(0, 1) == 1);
        burst        = $urandom_range(1, 24);
        back_to_back = 0;
        for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (phase == 0 && k == ITEMS_PER_PHASE / 2) begin
                // stall the output long enough that the queue fills up
                hold_off_req++;
                back_to_back = PRESSURE_ITEMS;
            end
            if (do_pause && k == ITEMS_PER_PHASE / 4) begin
                idle_sender(1);
                while (pending != 0) @(negedge i_clk);
            end
            make_position(code, valid);
            send_position(code, valid);
            if (back_to_back > 0) begin
                back_to_back--;
            end else if (--burst == 0) begin
                burst = $urandom_range(1, 24);
                if (with_gaps) idle_sender($urandom_range(1, 6));
            end
        end
    endtask

    // output side: segments of random stall patterns plus one long hold on request
    initial begin
        int seg_len, mode, seen_hold;
        seen_hold = 0;
        forever begin
            seg_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(negedge i_clk);
                if (hold_off_req != seen_hold) begin
                    seen_hold = hold_off_req;
                    i_m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        0:       i_m_axis_tready <= 1'b1;
                        1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                        default: i_m_axis_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one template, no thresholds
        send_position(16'h0000, 16'h0000);
        send_position(16'h0001, 16'h0001);
        send_position(16'h0000, 16'h0001);
        send_position(16'hFFFF, 16'hFFFE);   // only ignored templates valid

        load_settings(16, 0, 0, 0, 0);
        send_position(16'h0000, 16'hFFFF);
        send_position(16'hFFFF, 16'hFFFF);
        send_position(16'h00FF, 16'hFFFF);   // tie goes to zero
        send_position(16'h7FFF, 16'hFFFF);
        send_position(16'h5555, 16'h00FF);
        send_position(16'hFFFF, 16'h0001);

        // full mask required, consistency exactly three quarters
        load_settings(16, Q16_ONE, 49152, 0, 0);
        send_position(16'hFFFF, 16'hFFFF);
        send_position(16'hFFFF, 16'h7FFF);
        send_position(16'h0FFF, 16'hFFFF);
        send_position(16'h07FF, 16'hFFFF);   // inconsistent, masked out

        // inconsistent bits kept with a fallback weight above one
        load_settings(16, 0, Q16_ONE, 1, FRAC_MAX);
        send_position(16'h7FFF, 16'hFFFF);
        send_position(16'hFFFF, 16'hFFFF);

        load_settings(0, 0, 0, 0, 0);        // no template votes
        send_position(16'hFFFF, 16'hFFFF);

        load_settings(31, FRAC_MAX, 0, 0, 0); // clamped count, unreachable mask
        send_position(16'hFFFF, 16'hFFFF);

        load_settings(5, 0, FRAC_MAX, 1, 12345); // unreachable consistency
        send_position(16'h001F, 16'h001F);

        drain_results();
        for (int k = 0; k <= 2; k++) begin
            write_register(CFG_FIRST_UNUSED + CFG_IDX_W'(k), FRAC_W'($urandom));
        end
        send_position(16'h0003, 16'h001F);

        for (int p = 0; p < NUM_PHASES; p++) begin
            run_random_phase(p);
        end

        idle_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: masked_bit_majority_vote.f
hdl/mbv_pkg.sv
hdl/mbv_front.sv
hdl/mbv_fifo.sv
hdl/mbv_back.sv
hdl/masked_bit_majority_vote.sv
tb/mbv_vote_checker.sv
tb/testbench.sv
